### rtl/mme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mme_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;

  // widths of the ports
  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int IN_ELEM_W = 16;
  localparam int VALUE_W   = 35;

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  typedef logic [1:0] req_t;
  localparam req_t REQ_WR_A  = 2'd0;
  localparam req_t REQ_WR_B  = 2'd1;
  localparam req_t REQ_START = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROWS_A    = 2'd0;
  localparam cfg_idx_t CFG_INNER_DIM = 2'd1;
  localparam cfg_idx_t CFG_COLS_B    = 2'd2;

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic [DIM_W-1:0]            dim_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [ADDR_W-1:0]           addr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // tag that travels with each product through the mac pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last_term;
    logic last_elem;
    idx_t row;
    idx_t col;
  } tag_t;

  function automatic dim_t clamp_dim(dim_t d);
    dim_t r;
    r = d;
    if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic addr_t elem_addr(idx_t row, idx_t col);
    logic [2*IDX_W:0] full;
    full = (2*IDX_W+1)'(row) * (2*IDX_W+1)'(MAX_DIM) + (2*IDX_W+1)'(col);
    return full[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/mme_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module mme_mac (
  input  wire                                clk,
  input  wire                                rst_n,
  input  mme_pkg::tag_t                      tag_in,
  input  mme_pkg::elem_t                     a_in,
  input  mme_pkg::elem_t                     b_in,
  input  wire                                err_req,
  output logic                               res_valid,
  output mme_pkg::idx_t                      res_row,
  output mme_pkg::idx_t                      res_col,
  output logic signed [mme_pkg::VALUE_W-1:0] res_value,
  output logic                               res_last,
  output logic                               res_error
);

  mme_pkg::tag_t  prod_tag_r;
  mme_pkg::prod_t prod_r;
  mme_pkg::acc_t  acc_r;
  mme_pkg::acc_t  acc_nxt;

  logic                               out_valid_r;
  mme_pkg::idx_t                      out_row_r;
  mme_pkg::idx_t                      out_col_r;
  logic signed [mme_pkg::VALUE_W-1:0] out_value_r;
  logic                               out_last_r;
  logic                               out_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_tag_r <= '0;
    end else begin
      prod_tag_r <= tag_in;
    end
    prod_r <= a_in * b_in;
  end

  // a new dot product restarts the sum on its first term
  always_comb begin
    acc_nxt = (prod_tag_r.first ? '0 : acc_r) + mme_pkg::ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (prod_tag_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= err_req | (prod_tag_r.valid & prod_tag_r.last_term);
    end
    if (err_req) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_value_r <= '0;
      out_last_r  <= 1'b1;
      out_error_r <= 1'b1;
    end else begin
      out_row_r   <= prod_tag_r.row;
      out_col_r   <= prod_tag_r.col;
      out_value_r <= mme_pkg::VALUE_W'(acc_nxt);
      out_last_r  <= prod_tag_r.last_elem;
      out_error_r <= 1'b0;
    end
  end

  assign res_valid = out_valid_r;
  assign res_row   = out_row_r;
  assign res_col   = out_col_r;
  assign res_value = out_value_r;
  assign res_last  = out_last_r;
  assign res_error = out_error_r;

endmodule
`default_nettype wire

### rtl/matrix_multiply_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Dense C = A x B for matrices up to 8 by 8 with Q8.8 elements. A and B sit in
// two single-port-write, registered-read memories. Load items keep busy low.
// A start item holds busy high while the inner loop reads one element of A
// and one of B per cycle; its results appear in row-major order, each for
// exactly one cycle with out_valid high, and the final one carries out_last.
// The receiver cannot stall: every result must be taken in the cycle it is
// shown. A start with a zero dimension gives one result in the cycle right
// after it is taken, with out_error and out_last set. Dimension registers
// above 8 act as 8 and may be written only while busy is low.
module matrix_multiply_engine (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [1:0]                         in_req_type,
  input  wire  [mme_pkg::IDX_W-1:0]          in_row_index,
  input  wire  [mme_pkg::IDX_W-1:0]          in_col_index,
  input  wire  signed [mme_pkg::IN_ELEM_W-1:0] in_elem_value,
  output logic                               out_valid,
  output logic [mme_pkg::IDX_W-1:0]          out_row,
  output logic [mme_pkg::IDX_W-1:0]          out_col,
  output logic signed [mme_pkg::VALUE_W-1:0] out_value,
  output logic                               out_last,
  output logic                               out_error,
  input  wire                                cfg_we,
  input  wire  [1:0]                         cfg_index,
  input  wire  [mme_pkg::DIM_W-1:0]          cfg_data
);

  mme_pkg::state_t state_r, state_nxt;

  mme_pkg::dim_t rows_a_r, inner_dim_r, cols_b_r;
  mme_pkg::dim_t n_r, k_r, m_r;
  mme_pkg::dim_t n_cl, k_cl, m_cl;
  mme_pkg::idx_t i_r, j_r, p_r;
  mme_pkg::idx_t i_nxt, j_nxt, p_nxt;

  mme_pkg::elem_t mem_a [mme_pkg::MAX_DIM*mme_pkg::MAX_DIM];
  mme_pkg::elem_t mem_b [mme_pkg::MAX_DIM*mme_pkg::MAX_DIM];
  mme_pkg::elem_t rd_a_r, rd_b_r;
  mme_pkg::tag_t  rd_tag_r, issue_tag;

  logic accept, in_range, wr_a, wr_b, go, err_req, zero_dim;
  logic issue, last_term, last_col, last_row, done;
  mme_pkg::addr_t wr_addr, rd_addr_a, rd_addr_b;
  mme_pkg::elem_t wr_elem;

  logic                               res_valid, res_last;
  mme_pkg::idx_t                      res_row, res_col;
  logic signed [mme_pkg::VALUE_W-1:0] res_value;
  logic                               res_error;

  assign accept   = start & ~busy;
  assign in_range = ({1'b0, in_row_index} < mme_pkg::DIM_W'(mme_pkg::MAX_DIM)) &&
                    ({1'b0, in_col_index} < mme_pkg::DIM_W'(mme_pkg::MAX_DIM));
  assign wr_a     = accept && (in_req_type == mme_pkg::REQ_WR_A) && in_range;
  assign wr_b     = accept && (in_req_type == mme_pkg::REQ_WR_B) && in_range;
  assign n_cl     = mme_pkg::clamp_dim(rows_a_r);
  assign k_cl     = mme_pkg::clamp_dim(inner_dim_r);
  assign m_cl     = mme_pkg::clamp_dim(cols_b_r);
  assign zero_dim = (n_cl == '0) || (k_cl == '0) || (m_cl == '0);
  assign go       = accept && (in_req_type == mme_pkg::REQ_START) && !zero_dim;
  assign err_req  = accept && (in_req_type == mme_pkg::REQ_START) && zero_dim;
  assign wr_addr  = mme_pkg::elem_addr(in_row_index, in_col_index);
  assign wr_elem  = mme_pkg::ELEM_BITS'(in_elem_value);

  assign last_term = (mme_pkg::DIM_W'(p_r) == k_r - 1'b1);
  assign last_col  = (mme_pkg::DIM_W'(j_r) == m_r - 1'b1);
  assign last_row  = (mme_pkg::DIM_W'(i_r) == n_r - 1'b1);
  assign done      = res_valid && res_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mme_pkg::DIM_W'(8);
      inner_dim_r <= mme_pkg::DIM_W'(8);
      cols_b_r    <= mme_pkg::DIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mme_pkg::CFG_ROWS_A:    rows_a_r    <= cfg_data;
        mme_pkg::CFG_INNER_DIM: inner_dim_r <= cfg_data;
        mme_pkg::CFG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mme_pkg::ST_IDLE:  if (go) state_nxt = mme_pkg::ST_RUN;
      mme_pkg::ST_RUN:   if (last_term && last_col && last_row) state_nxt = mme_pkg::ST_DRAIN;
      mme_pkg::ST_DRAIN: if (done) state_nxt = mme_pkg::ST_IDLE;
      default:           state_nxt = mme_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    unique case (state_r)
      mme_pkg::ST_IDLE:  busy  = 1'b0;
      mme_pkg::ST_RUN:   issue = 1'b1;
      mme_pkg::ST_DRAIN: ;
      default:           busy  = 1'b0;
    endcase
  end

  // loop counters: p innermost, then column, then row
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    p_nxt = p_r;
    if (go) begin
      i_nxt = '0;
      j_nxt = '0;
      p_nxt = '0;
    end else if (issue) begin
      if (last_term) begin
        p_nxt = '0;
        if (last_col) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end else begin
        p_nxt = p_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
    end
    if (go) begin
      n_r <= n_cl;
      k_r <= k_cl;
      m_r <= m_cl;
    end
  end

  assign rd_addr_a = mme_pkg::elem_addr(i_r, p_r);
  assign rd_addr_b = mme_pkg::elem_addr(p_r, j_r);

  always_comb begin
    issue_tag.valid     = issue;
    issue_tag.first     = (p_r == '0);
    issue_tag.last_term = last_term;
    issue_tag.last_elem = last_col && last_row;
    issue_tag.row       = i_r;
    issue_tag.col       = j_r;
  end

  // element stores; loads and reads never overlap since loads need busy low
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= wr_elem;
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= wr_elem;
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r <= issue_tag;
    end
  end

  mme_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (rd_tag_r),
    .a_in      (rd_a_r),
    .b_in      (rd_b_r),
    .err_req   (err_req),
    .res_valid (res_valid),
    .res_row   (res_row),
    .res_col   (res_col),
    .res_value (res_value),
    .res_last  (res_last),
    .res_error (res_error)
  );

  assign out_valid = res_valid;
  assign out_row   = res_row;
  assign out_col   = res_col;
  assign out_value = res_value;
  assign out_last  = res_last;
  assign out_error = res_error;

endmodule
`default_nettype wire

### verif/matrix_product_checker.sv
`timescale 1ns / 1ps
module matrix_product_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire                           busy,
  input  wire  [1:0]                    in_req_type,
  input  wire  [mme_pkg::IDX_W-1:0]     in_row_index,
  input  wire  [mme_pkg::IDX_W-1:0]     in_col_index,
  input  wire  [mme_pkg::IN_ELEM_W-1:0] in_elem_value,
  input  wire                           out_valid,
  input  wire  [mme_pkg::IDX_W-1:0]     out_row,
  input  wire  [mme_pkg::IDX_W-1:0]     out_col,
  input  wire  [mme_pkg::VALUE_W-1:0]   out_value,
  input  wire                           out_last,
  input  wire                           out_error,
  input  wire                           cfg_we,
  input  wire  [1:0]                    cfg_index,
  input  wire  [mme_pkg::DIM_W-1:0]     cfg_data,
  output int                            pending,
  output int                            failures
);

  typedef struct packed {
    logic [mme_pkg::IDX_W-1:0]   row;
    logic [mme_pkg::IDX_W-1:0]   col;
    logic [mme_pkg::VALUE_W-1:0] value;
    logic                        last;
    logic                        error;
  } c_elem_t;

  logic signed [15:0]          store_a [64];
  logic signed [15:0]          store_b [64];
  logic [mme_pkg::DIM_W-1:0]   dim_rows;
  logic [mme_pkg::DIM_W-1:0]   dim_inner;
  logic [mme_pkg::DIM_W-1:0]   dim_cols;
  c_elem_t                     expected_elems [$];

  function automatic int limit_dim(logic [mme_pkg::DIM_W-1:0] d);
    return (d > 4'd8) ? 8 : int'(d);
  endfunction

  // every element of C for the current dimensions, row-major, or one error result if a dimension is zero
  task automatic queue_products();
    int      n;
    int      k;
    int      m;
    int      i;
    int      j;
    int      p;
    longint  acc;
    c_elem_t e;
    n = limit_dim(dim_rows);
    k = limit_dim(dim_inner);
    m = limit_dim(dim_cols);
    if (n == 0 || k == 0 || m == 0) begin
      e = '0;
      e.last = 1'b1;
      e.error = 1'b1;
      expected_elems.push_back(e);
    end else begin
      for (i = 0; i < n; i++) begin
        for (j = 0; j < m; j++) begin
          acc = 0;
          for (p = 0; p < k; p++) begin
            acc += longint'(store_a[i*8+p]) * longint'(store_b[p*8+j]);
          end
          e.row = i[2:0];
          e.col = j[2:0];
          e.value = acc[mme_pkg::VALUE_W-1:0];
          e.last = (i == n - 1) && (j == m - 1);
          e.error = 1'b0;
          expected_elems.push_back(e);
        end
      end
    end
  endtask

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    c_elem_t got;
    c_elem_t want;
    if (!rst_n) begin
      dim_rows = 4'd8;
      dim_inner = 4'd8;
      dim_cols = 4'd8;
      foreach (store_a[idx]) begin
        store_a[idx] = '0;
        store_b[idx] = '0;
      end
      expected_elems.delete();
      failures = 0;
    end else begin
      if (out_valid) begin
        got = {out_row, out_col, out_value, out_last, out_error};
        if (expected_elems.size() == 0) begin
          note_failure($sformatf("unexpected result row %0d col %0d value %0d last %0d err %0d",
                                 got.row, got.col, $signed(got.value), got.last, got.error));
        end else begin
          want = expected_elems.pop_front();
          if (got !== want) begin
            note_failure($sformatf({"mismatch: expected row %0d col %0d value %0d last %0d ",
                                    "err %0d, got row %0d col %0d value %0d last %0d err %0d"},
                                   want.row, want.col, $signed(want.value), want.last,
                                   want.error, got.row, got.col, $signed(got.value),
                                   got.last, got.error));
          end
        end
      end
      if (start && !busy) begin
        case (in_req_type)
          mme_pkg::REQ_WR_A:  store_a[{in_row_index, in_col_index}] = in_elem_value;
          mme_pkg::REQ_WR_B:  store_b[{in_row_index, in_col_index}] = in_elem_value;
          mme_pkg::REQ_START: queue_products();
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          mme_pkg::CFG_ROWS_A:    dim_rows = cfg_data;
          mme_pkg::CFG_INNER_DIM: dim_inner = cfg_data;
          mme_pkg::CFG_COLS_B:    dim_cols = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= expected_elems.size();
  end

endmodule

### verif/matrix_multiply_engine_tb.sv
`timescale 1ns / 1ps
module matrix_multiply_engine_tb;

  localparam mme_pkg::req_t REQ_NONE = 2'd3;
  localparam int   CYCLE_LIMIT   = 2_000_000;
  localparam int   ITEM_TARGET   = 220;
  localparam int   SETTLE_CYCLES = 8;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic [1:0]                     in_req_type = '0;
  logic [mme_pkg::IDX_W-1:0]      in_row_index = '0;
  logic [mme_pkg::IDX_W-1:0]      in_col_index = '0;
  logic [mme_pkg::IN_ELEM_W-1:0]  in_elem_value = '0;
  logic                           cfg_we = 1'b0;
  logic [1:0]                     cfg_index = '0;
  logic [mme_pkg::DIM_W-1:0]      cfg_data = '0;

  wire                            busy;
  wire                            out_valid;
  wire [mme_pkg::IDX_W-1:0]       out_row;
  wire [mme_pkg::IDX_W-1:0]       out_col;
  wire [mme_pkg::VALUE_W-1:0]     out_value;
  wire                            out_last;
  wire                            out_error;

  int                             pending;
  int                             failures;
  int                             cycles = 0;
  int                             idle_pct = 0;
  int                             items_sent = 0;
  bit                             loaded_a [64];
  bit                             loaded_b [64];
  logic [mme_pkg::DIM_W-1:0]      rows_cfg = 4'd8;
  logic [mme_pkg::DIM_W-1:0]      inner_cfg = 4'd8;
  logic [mme_pkg::DIM_W-1:0]      cols_cfg = 4'd8;

  matrix_multiply_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_elem_value(in_elem_value),
    .out_valid    (out_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_error    (out_error),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  matrix_product_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_elem_value(in_elem_value),
    .out_valid    (out_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_error    (out_error),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .failures     (failures)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [mme_pkg::DIM_W-1:0] rand_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      return 4'd0;
    end else if (roll < 22) begin
      return 4'd8;
    end else if (roll < 30) begin
      return mme_pkg::DIM_W'($urandom_range(15, 9));
    end
    return mme_pkg::DIM_W'($urandom_range(3, 1));
  endfunction

  // start stays high until the item is taken
  task automatic send_item(mme_pkg::req_t req, mme_pkg::idx_t row, mme_pkg::idx_t col,
                           logic [15:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_row_index <= row;
    in_col_index <= col;
    in_elem_value <= val;
    do @(posedge clk); while (busy);
    if (req == mme_pkg::REQ_WR_A) begin
      loaded_a[{row, col}] = 1'b1;
    end else if (req == mme_pkg::REQ_WR_B) begin
      loaded_b[{row, col}] = 1'b1;
    end
    if (req != REQ_NONE) begin
      items_sent++;
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(mme_pkg::cfg_idx_t idx, logic [mme_pkg::DIM_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_dims(logic [mme_pkg::DIM_W-1:0] r, logic [mme_pkg::DIM_W-1:0] k,
                          logic [mme_pkg::DIM_W-1:0] c);
    wait_quiet();
    write_cfg(mme_pkg::CFG_ROWS_A, r);
    write_cfg(mme_pkg::CFG_INNER_DIM, k);
    write_cfg(mme_pkg::CFG_COLS_B, c);
    cfg_we <= 1'b0;
    rows_cfg = r;
    inner_cfg = k;
    cols_cfg = c;
  endtask

  // load whatever the next start would read that was never written, then send the start
  task automatic start_product();
    int n;
    int k;
    int m;
    int i;
    int j;
    int p;
    n = (rows_cfg > 4'd8) ? 8 : int'(rows_cfg);
    k = (inner_cfg > 4'd8) ? 8 : int'(inner_cfg);
    m = (cols_cfg > 4'd8) ? 8 : int'(cols_cfg);
    if (n != 0 && k != 0 && m != 0) begin
      for (i = 0; i < n; i++) begin
        for (p = 0; p < k; p++) begin
          if (!loaded_a[i*8+p]) begin
            send_item(mme_pkg::REQ_WR_A, mme_pkg::idx_t'(i), mme_pkg::idx_t'(p), rand_elem());
          end
        end
      end
      for (p = 0; p < k; p++) begin
        for (j = 0; j < m; j++) begin
          if (!loaded_b[p*8+j]) begin
            send_item(mme_pkg::REQ_WR_B, mme_pkg::idx_t'(p), mme_pkg::idx_t'(j), rand_elem());
          end
        end
      end
    end
    send_item(mme_pkg::REQ_START, mme_pkg::idx_t'($urandom_range(7)),
              mme_pkg::idx_t'($urandom_range(7)), rand_elem());
  endtask

  initial begin
    int p;
    int phase;
    int burst;
    int roll;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 20;

    // one depth-8 dot product at the most positive and most negative sums
    set_dims(4'd1, 4'd8, 4'd1);
    for (p = 0; p < 8; p++) send_item(mme_pkg::REQ_WR_A, 3'd0, mme_pkg::idx_t'(p), 16'h8000);
    for (p = 0; p < 8; p++) send_item(mme_pkg::REQ_WR_B, mme_pkg::idx_t'(p), 3'd0, 16'h8000);
    send_item(mme_pkg::REQ_START, 3'd7, 3'd7, 16'hffff);
    for (p = 0; p < 8; p++) send_item(mme_pkg::REQ_WR_A, 3'd0, mme_pkg::idx_t'(p), 16'h7fff);
    send_item(mme_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
    send_item(REQ_NONE, 3'd5, 3'd2, 16'h1234);
    // zero rows gives a single error result
    set_dims(4'd0, 4'd8, 4'd8);
    send_item(mme_pkg::REQ_START, 3'd1, 3'd6, 16'h5a5a);

    items_sent = 0;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        idle_pct = 20;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        idle_pct = 48;
      end else begin
        idle_pct = 0;
      end
      case (phase)
        0: set_dims(4'd8, 4'd8, 4'd8);
        1: set_dims(4'd1, 4'd0, 4'd3);
        2: set_dims(4'd2, 4'd5, 4'd0);
        3: set_dims(4'd15, 4'd1, 4'd9);
        default: set_dims(rand_dim(), rand_dim(), rand_dim());
      endcase
      burst = $urandom_range(20, 4);
      repeat (burst) begin
        roll = $urandom_range(99);
        if (roll < 65) begin
          send_item(mme_pkg::req_t'($urandom_range(1)), mme_pkg::idx_t'($urandom_range(7)),
                    mme_pkg::idx_t'($urandom_range(7)), rand_elem());
        end else if (roll < 72) begin
          send_item(REQ_NONE, mme_pkg::idx_t'($urandom_range(7)),
                    mme_pkg::idx_t'($urandom_range(7)), 16'($urandom));
        end else begin
          start_product();
        end
      end
      start_product();
      phase++;
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/mme_pkg.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine.sv
verif/matrix_product_checker.sv
verif/matrix_multiply_engine_tb.sv
